// File: rtl/topological_sort_kahn_assert.svh
// ----------------------------------------------------------------------------
// topological_sort_kahn assertion macros
// Shared concurrent assertion forms for the sort block.
// ----------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_KAHN_ASSERT_SVH
`define TOPOLOGICAL_SORT_KAHN_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tsk_pkg.sv
// ----------------------------------------------------------------------------
// tsk_pkg
// Shared constants and controller/datapath interface types for the sort block.
// ----------------------------------------------------------------------------
package tsk_pkg;

    localparam int NODE_W = 7;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_NODE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_CYCLE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic add;      // add-edge beat accepted
        logic inc_wr;   // write back raised in-degree
        logic idx_clr;  // restart the walk index
        logic chk_rd;
        logic chk_ev;
        logic seed_rd;
        logic seed_ev;
        logic pop_rd;
        logic pop_ev;
        logic scan_rd;
        logic scan_ev;
        logic dec_wr;
        logic out_rd;
        logic out_ld;
        logic err_ld;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_run;
        logic idx_lt_edges;
        logic idx_last_node;
        logic q_nonempty;
        logic all_ordered;
        logic ovf;
        logic src_match;
        logic out_acc;
        logic out_last;
    } t_stat;

endpackage

// File: rtl/tsk_ctrl.sv
// ----------------------------------------------------------------------------
// tsk_ctrl
// Sequencer for edge loading, range check, seeding, queue walk and output.
// ----------------------------------------------------------------------------
module tsk_ctrl
    import tsk_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INC      = 4'd1;
    localparam logic [3:0] S_CHK_RD   = 4'd2;
    localparam logic [3:0] S_CHK_EV   = 4'd3;
    localparam logic [3:0] S_SEED_RD  = 4'd4;
    localparam logic [3:0] S_SEED_EV  = 4'd5;
    localparam logic [3:0] S_POP_CHK  = 4'd6;
    localparam logic [3:0] S_POP_EV   = 4'd7;
    localparam logic [3:0] S_SCAN_RD  = 4'd8;
    localparam logic [3:0] S_SCAN_EV  = 4'd9;
    localparam logic [3:0] S_DEC      = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;
    localparam logic [3:0] S_OUT_RD   = 4'd12;
    localparam logic [3:0] S_OUT_LD   = 4'd13;
    localparam logic [3:0] S_ERR      = 4'd14;
    localparam logic [3:0] S_OUT_WAIT = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    if (i_stat.in_run) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_CHK_RD;
                    end else begin
                        o_cmd.add = 1'b1;
                        n_state   = S_INC;
                    end
                end
            end
            S_INC: begin
                o_cmd.inc_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_CHK_RD: begin
                priority if (i_stat.idx_lt_edges) begin
                    o_cmd.chk_rd = 1'b1;
                    n_state      = S_CHK_EV;
                end else if (i_stat.ovf) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SEED_RD;
                end
            end
            S_CHK_EV: begin
                o_cmd.chk_ev = 1'b1;
                n_state      = S_CHK_RD;
            end
            S_SEED_RD: begin
                o_cmd.seed_rd = 1'b1;
                n_state       = S_SEED_EV;
            end
            S_SEED_EV: begin
                o_cmd.seed_ev = 1'b1;
                n_state       = i_stat.idx_last_node ? S_POP_CHK : S_SEED_RD;
            end
            S_POP_CHK: begin
                if (i_stat.q_nonempty) begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = S_POP_EV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_EV: begin
                o_cmd.pop_ev = 1'b1;
                n_state      = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (i_stat.idx_lt_edges) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN_EV;
                end else begin
                    n_state = S_POP_CHK;
                end
            end
            S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                n_state       = i_stat.src_match ? S_DEC : S_SCAN_RD;
            end
            S_DEC: begin
                o_cmd.dec_wr = 1'b1;
                n_state      = S_SCAN_RD;
            end
            S_FIN: begin
                if (i_stat.all_ordered) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_OUT_RD;
                end else begin
                    n_state = S_ERR;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = S_OUT_WAIT;
            end
            S_ERR: begin
                o_cmd.err_ld = 1'b1;
                n_state      = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_stat.out_acc) begin
                    n_state = i_stat.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/tsk_dp.sv
// ----------------------------------------------------------------------------
// tsk_dp
// Edge store, in-degree table, ready queue, walk counters and output register.
// ----------------------------------------------------------------------------
module tsk_dp
    import tsk_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    input  logic [NODE_W-1:0] i_from,
    input  logic [NODE_W-1:0] i_to,
    input  logic              i_cfg_we,
    input  logic [NODE_W-1:0] i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_out_status,
    output logic [NODE_W-1:0] o_out_node,
    output logic              o_out_last
);

    localparam int NIW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int EAW = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int QW  = $clog2(MAX_NODES + 1);
    localparam int IW  = (ECW > QW) ? ECW : QW;
    localparam int XW  = (IW > NODE_W) ? IW : NODE_W;
    localparam logic [NODE_W-1:0] NMAX = NODE_W'(MAX_NODES);

    // memories
    logic [NIW-1:0] m_src [MAX_EDGES];
    logic [NIW-1:0] m_tgt [MAX_EDGES];
    logic [ECW-1:0] m_deg [MAX_NODES];
    logic [NIW-1:0] m_q   [MAX_NODES];

    logic [NODE_W-1:0]    r_cfg;
    logic [ECW-1:0]       r_ecnt;
    logic [QW-1:0]        r_head;
    logic [QW-1:0]        r_tail;
    logic                 r_ovf;
    logic [IW-1:0]        r_idx;
    logic [NIW-1:0]       r_cur;
    logic [NIW-1:0]       r_add_tgt;
    logic                 r_add_ok;
    logic [MAX_NODES-1:0] r_deg_vld;
    logic [NIW-1:0]       r_src_q;
    logic [NIW-1:0]       r_tgt_q;
    logic [ECW-1:0]       r_deg_q;
    logic                 r_deg_vq;
    logic [NIW-1:0]       r_q_q;
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_out_status;
    logic [NODE_W-1:0]    r_out_node;
    logic                 r_out_last;

    logic [NODE_W-1:0] n_eff;
    logic              add_bad;
    logic [ECW-1:0]    deg_val;
    logic              deg_re;
    logic [NIW-1:0]    deg_raddr;
    logic              deg_we;
    logic [NIW-1:0]    deg_waddr;
    logic [ECW-1:0]    deg_wdata;
    logic              q_we;
    logic [NIW-1:0]    q_wdata;
    logic              q_re;
    logic [NIW-1:0]    q_raddr;
    logic              e_re;
    logic              out_acc;
    logic              run_done;

    always_comb begin
        priority if (r_cfg == '0) n_eff = NODE_W'(1);
        else if (r_cfg > NMAX)    n_eff = NMAX;
        else                      n_eff = r_cfg;
    end

    assign add_bad = (i_from == '0) || (i_to == '0) || (i_from > n_eff) || (i_to > n_eff)
                   || (r_ecnt >= ECW'(MAX_EDGES));
    assign deg_val = r_deg_vq ? r_deg_q : '0;
    assign out_acc  = r_out_valid && i_out_ready;
    assign run_done = out_acc && r_out_last;

    // in-degree port selection
    always_comb begin
        deg_re    = i_cmd.add || i_cmd.seed_rd || (i_cmd.scan_ev && o_stat.src_match);
        deg_raddr = r_idx[NIW-1:0];
        if (i_cmd.add)          deg_raddr = NIW'(i_to - NODE_W'(1));
        else if (i_cmd.scan_ev) deg_raddr = r_tgt_q;
        deg_we    = (i_cmd.inc_wr && r_add_ok) || (i_cmd.dec_wr && (deg_val != '0));
        deg_waddr = i_cmd.inc_wr ? r_add_tgt : r_tgt_q;
        deg_wdata = i_cmd.inc_wr ? (deg_val + ECW'(1)) : (deg_val - ECW'(1));
    end

    // ready queue push: seeding or a target reaching zero
    always_comb begin
        q_we    = (i_cmd.seed_ev && (deg_val == '0))
                || (i_cmd.dec_wr && (deg_val == ECW'(1)));
        q_wdata = i_cmd.seed_ev ? r_idx[NIW-1:0] : r_tgt_q;
        q_re    = i_cmd.pop_rd || i_cmd.out_rd;
        q_raddr = i_cmd.pop_rd ? r_head[NIW-1:0] : r_idx[NIW-1:0];
        e_re    = i_cmd.chk_rd || i_cmd.scan_rd;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add && !add_bad) begin
            m_src[r_ecnt[EAW-1:0]] <= NIW'(i_from - NODE_W'(1));
            m_tgt[r_ecnt[EAW-1:0]] <= NIW'(i_to - NODE_W'(1));
        end
        if (e_re) begin
            r_src_q <= m_src[r_idx[EAW-1:0]];
            r_tgt_q <= m_tgt[r_idx[EAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            m_deg[deg_waddr] <= deg_wdata;
        end
        if (deg_re) begin
            r_deg_q <= m_deg[deg_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_q[r_tail[NIW-1:0]] <= q_wdata;
        end
        if (q_re) begin
            r_q_q <= m_q[q_raddr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_add_tgt <= NIW'(i_to - NODE_W'(1));
        end
        if (i_cmd.pop_ev) begin
            r_cur <= r_q_q;
        end
        if (deg_re) begin
            r_deg_vq <= r_deg_vld[deg_raddr];
        end
        if (i_cmd.out_ld) begin
            r_out_status <= STAT_NODE;
            r_out_node   <= NODE_W'(r_q_q) + NODE_W'(1);
            r_out_last   <= (XW'(r_idx) == XW'(n_eff) - XW'(1));
        end else if (i_cmd.err_ld) begin
            r_out_status <= r_ovf ? STAT_OVF : STAT_CYCLE;
            r_out_node   <= '0;
            r_out_last   <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= NMAX;
            r_ecnt      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_add_ok    <= 1'b0;
            r_deg_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.add) begin
                r_add_ok <= !add_bad;
                if (add_bad) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_ecnt <= r_ecnt + ECW'(1);
                end
            end
            if (deg_we) begin
                r_deg_vld[deg_waddr] <= 1'b1;
            end
            if (i_cmd.chk_ev &&
                ((XW'(r_src_q) >= XW'(n_eff)) || (XW'(r_tgt_q) >= XW'(n_eff)))) begin
                r_ovf <= 1'b1;
            end
            if (q_we) begin
                r_tail <= r_tail + QW'(1);
            end
            if (i_cmd.pop_ev) begin
                r_head <= r_head + QW'(1);
            end
            priority if (i_cmd.idx_clr || i_cmd.pop_ev) begin
                r_idx <= '0;
            end else if (i_cmd.chk_ev || i_cmd.seed_ev || i_cmd.scan_ev || i_cmd.out_ld) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.out_ld || i_cmd.err_ld) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            // every run ends by clearing its working state
            if (run_done) begin
                r_ecnt    <= '0;
                r_head    <= '0;
                r_tail    <= '0;
                r_ovf     <= 1'b0;
                r_deg_vld <= '0;
            end
        end
    end

    always_comb begin
        o_stat.in_valid      = i_in_valid;
        o_stat.in_run        = (i_in_cmd == CMD_RUN);
        o_stat.idx_lt_edges  = (XW'(r_idx) < XW'(r_ecnt));
        o_stat.idx_last_node = (XW'(r_idx) == XW'(n_eff) - XW'(1));
        o_stat.q_nonempty    = (r_head < r_tail);
        o_stat.all_ordered   = (XW'(r_head) == XW'(n_eff));
        o_stat.ovf           = r_ovf;
        o_stat.src_match     = (r_src_q == r_cur);
        o_stat.out_acc       = out_acc;
        o_stat.out_last      = r_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_node   = r_out_node;
    assign o_out_last   = r_out_last;

endmodule

// File: rtl/topological_sort_kahn.sv
// ----------------------------------------------------------------------------
// topological_sort_kahn
// Kahn topological sort over edges loaded one beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tuser = command (0 add edge, 1 run); tdata = from_node [6:0],
//   to_node [13:7]. An add beat stores the edge and raises the target's
//   in-degree; it yields nothing, and is handled as accept, then in-degree write.
//   A run beat checks all E stored edges, seeds the ready queue over N nodes,
//   then for each popped node scans all stored edges, with an in-degree
//   decrement for each matching edge; every edge walk is serial through
//   the single read port of the edge store. m_axis: tuser = status,
//   tdata = node, tlast on the final beat. The full order is emitted after
//   the sort finishes, each beat taken before the next is read from the queue;
//   a cycle or a bad edge gives a single beat instead.
//   One item is handled at a time; s_axis_tready is low until the final result
//   beat is taken, so a stalled receiver holds the block. The run clears the
//   edge store, in-degrees and overflow flag; node_count is kept.
//   Reset (i_rst_n low, synchronous) empties the store and sets node_count to
//   MAX_NODES; no clearing pass is needed.
//   cfg: i_cfg_valid/o_cfg_ready write node_count, only while idle.
// ----------------------------------------------------------------------------
module topological_sort_kahn
    import tsk_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // from_node [6:0], to_node [13:7], zero [15:14]
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // node [6:0], zero [7]
    output logic [1:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    `include "topological_sort_kahn_assert.svh"

    t_cmd              cmd;
    t_stat             stat;
    logic              in_ready;
    logic [NODE_W-1:0] out_node;

    tsk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    tsk_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_valid   (s_axis_tvalid && in_ready),
        .i_in_cmd     (s_axis_tuser),
        .i_from       (s_axis_tdata[6:0]),
        .i_to         (s_axis_tdata[13:7]),
        .i_cfg_we     (i_cfg_valid && in_ready),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_node   (out_node),
        .o_out_last   (m_axis_tlast)
    );

    assign s_axis_tready = in_ready;
    assign o_cfg_ready   = in_ready;
    assign m_axis_tdata  = {1'b0, out_node};

    `TSK_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready,
        "result pending while input is open")
    `TSK_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready,
        "block not idle after final beat")
    `TSK_ASSERT_NOW(a_node_only_ordered, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != STAT_NODE), (m_axis_tdata == 8'd0) && m_axis_tlast,
        "error beat carries a node or is not final")
    `TSK_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tuser == STAT_NODE) || (m_axis_tuser == STAT_CYCLE) || (m_axis_tuser == STAT_OVF),
        "undefined status code")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for topological_sort_kahn: directed table then random graphs,
// every output beat checked against an in-bench Kahn sort predictor or a typed result.
// ----------------------------------------------------------------------------
module tb;
    import tsk_pkg::*;

    localparam int NODES_MAX  = 64;
    localparam int EDGES_MAX  = 256;
    localparam int STALL_LIM  = 400000;

    typedef enum logic [1:0] {OP_ADD, OP_RUN, OP_CFG} t_op;

    typedef struct {
        logic [1:0] status;
        logic [6:0] node;
        logic       last;
    } t_sort_beat;

    typedef struct {
        t_op        op;
        logic [6:0] a;        // from_node, or node_count for OP_CFG
        logic [6:0] b;        // to_node
        bit         typed;    // single typed result instead of predictor output
        logic [1:0] t_status;
        logic [6:0] t_node;
    } t_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;

    topological_sort_kahn dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // predictor state
    logic [6:0]  node_count_reg;
    int          edge_src [EDGES_MAX];
    int          edge_dst [EDGES_MAX];
    int          edge_total;
    int          in_deg [NODES_MAX];
    bit          bad_edge_seen;

    t_sort_beat  expected_beats[$];
    int          error_count = 0;
    int          items_sent;
    int          burst_left;
    int          idle_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int active_nodes();
        if (node_count_reg == 0) return 1;
        if (node_count_reg > NODES_MAX) return NODES_MAX;
        return int'(node_count_reg);
    endfunction

    function automatic void clear_sort_state();
        edge_total = 0;
        bad_edge_seen = 0;
        foreach (in_deg[i]) in_deg[i] = 0;
    endfunction

    function automatic void store_edge(input logic [6:0] u, input logic [6:0] v);
        int n;
        n = active_nodes();
        if (u == 0 || v == 0 || u > n || v > n || edge_total >= EDGES_MAX) begin
            bad_edge_seen = 1;
        end else begin
            edge_src[edge_total] = int'(u) - 1;
            edge_dst[edge_total] = int'(v) - 1;
            in_deg[int'(v) - 1]++;
            edge_total++;
        end
    endfunction

    function automatic void sort_graph();
        int         n;
        int         cur;
        int         ready_q[$];
        t_sort_beat order[$];
        t_sort_beat b;
        n = active_nodes();
        for (int e = 0; e < edge_total; e++)
            if (edge_src[e] >= n || edge_dst[e] >= n) bad_edge_seen = 1;
        if (bad_edge_seen) begin
            b.status = STAT_OVF; b.node = 0; b.last = 1;
            expected_beats.insert(expected_beats.size(), b);
            clear_sort_state();
            return;
        end
        for (int i = 0; i < n; i++)
            if (in_deg[i] == 0) ready_q.insert(ready_q.size(), i);
        while (ready_q.size() > 0) begin
            cur = ready_q.pop_front();
            b.status = STAT_NODE; b.node = 7'(cur + 1); b.last = 0;
            order.insert(order.size(), b);
            for (int e = 0; e < edge_total; e++) begin
                if (edge_src[e] == cur && in_deg[edge_dst[e]] != 0) begin
                    in_deg[edge_dst[e]]--;
                    if (in_deg[edge_dst[e]] == 0) ready_q.insert(ready_q.size(), edge_dst[e]);
                end
            end
        end
        if (order.size() < n) begin
            b.status = STAT_CYCLE; b.node = 0; b.last = 1;
            expected_beats.insert(expected_beats.size(), b);
        end else begin
            order[order.size() - 1].last = 1;
            foreach (order[i]) expected_beats.insert(expected_beats.size(), order[i]);
        end
        clear_sort_state();
    endfunction

    // sender: bursts with random gaps; entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic [6:0] u, input logic [6:0] v);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        s_axis_tuser  = cmd;
        s_axis_tdata  = {2'b00, v, u};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        items_sent++;
        if (cmd == CMD_ADD) store_edge(u, v);
        else sort_graph();
        @(negedge i_clk);
    endtask

    task automatic write_node_count(input logic [6:0] value);
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);   // an add beat can still be in flight
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        node_count_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_step(input t_step s);
        int         keep;
        t_sort_beat typed_beat;
        if (s.op == OP_CFG) begin
            write_node_count(s.a);
        end else if (s.op == OP_ADD) begin
            send_item(CMD_ADD, s.a, s.b);
        end else begin
            keep = expected_beats.size();
            send_item(CMD_RUN, s.a, s.b);
            if (s.typed) begin
                while (expected_beats.size() > keep) void'(expected_beats.pop_back());
                typed_beat.status = s.t_status;
                typed_beat.node   = s.t_node;
                typed_beat.last   = 1'b1;
                expected_beats.insert(expected_beats.size(), typed_beat);
            end
        end
    endtask

    // receiver stall pattern, reshuffled whenever the phase counter wraps
    int stall_mode = 0;
    int stall_phase = 0;
    always @(negedge i_clk) begin
        if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
        stall_phase <= (stall_phase + 1) % 64;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_phase % 8) < 5;
        endcase
    end

    always @(posedge i_clk) begin
        t_sort_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status=%0d node=%0d",
                                          m_axis_tuser, m_axis_tdata[6:0]));
            end else begin
                want = expected_beats.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_axis_tuser, want.status));
                if (m_axis_tdata !== {1'b0, want.node})
                    report_mismatch($sformatf("node %0d, want %0d",
                                              m_axis_tdata, want.node));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIM) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_step directed [] = '{
        '{OP_RUN, 7'd0,   7'd0,   1'b0, STAT_NODE,  7'd0},  // empty graph: 1..64
        '{OP_ADD, 7'd1,   7'd64,  1'b0, STAT_NODE,  7'd0},
        '{OP_ADD, 7'd64,  7'd1,   1'b0, STAT_NODE,  7'd0},
        '{OP_RUN, 7'd127, 7'd127, 1'b1, STAT_CYCLE, 7'd0},
        '{OP_ADD, 7'd0,   7'd5,   1'b0, STAT_NODE,  7'd0},
        '{OP_RUN, 7'd0,   7'd0,   1'b1, STAT_OVF,   7'd0},
        '{OP_ADD, 7'd65,  7'd1,   1'b0, STAT_NODE,  7'd0},
        '{OP_RUN, 7'd0,   7'd0,   1'b1, STAT_OVF,   7'd0},
        '{OP_ADD, 7'd127, 7'd127, 1'b0, STAT_NODE,  7'd0},
        '{OP_RUN, 7'd0,   7'd0,   1'b1, STAT_OVF,   7'd0},
        '{OP_ADD, 7'd1,   7'd2,   1'b0, STAT_NODE,  7'd0},
        '{OP_ADD, 7'd2,   7'd3,   1'b0, STAT_NODE,  7'd0},
        '{OP_ADD, 7'd1,   7'd3,   1'b0, STAT_NODE,  7'd0},
        '{OP_ADD, 7'd64,  7'd63,  1'b0, STAT_NODE,  7'd0},
        '{OP_RUN, 7'd0,   7'd0,   1'b0, STAT_NODE,  7'd0},
        '{OP_ADD, 7'd3,   7'd3,   1'b0, STAT_NODE,  7'd0},  // self loop
        '{OP_RUN, 7'd0,   7'd0,   1'b1, STAT_CYCLE, 7'd0},
        '{OP_CFG, 7'd127, 7'd0,   1'b0, STAT_NODE,  7'd0},  // clamps to 64
        '{OP_ADD, 7'd64,  7'd1,   1'b0, STAT_NODE,  7'd0},
        '{OP_CFG, 7'd3,   7'd0,   1'b0, STAT_NODE,  7'd0},  // lowered after load
        '{OP_RUN, 7'd0,   7'd0,   1'b1, STAT_OVF,   7'd0},
        '{OP_CFG, 7'd0,   7'd0,   1'b0, STAT_NODE,  7'd0},  // acts as 1
        '{OP_RUN, 7'd0,   7'd0,   1'b1, STAT_NODE,  7'd1},
        '{OP_ADD, 7'd1,   7'd1,   1'b0, STAT_NODE,  7'd0},
        '{OP_RUN, 7'd0,   7'd0,   1'b1, STAT_CYCLE, 7'd0}
    };

    initial begin
        int         n;
        int         edges;
        int         pick;
        bit         flood_done;
        logic [6:0] u;
        logic [6:0] v;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ADD;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        items_sent    = 0;
        burst_left    = 0;
        flood_done    = 0;
        node_count_reg = 7'(NODES_MAX);
        clear_sort_state();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) run_step(directed[i]);

        while (items_sent < 450 || !flood_done) begin
            if (!flood_done && items_sent >= 150) begin
                // store overflow: one more edge than the store holds
                write_node_count(7'd4);
                for (int k = 0; k <= EDGES_MAX; k++)
                    send_item(CMD_ADD, 7'($urandom_range(1, 3)), 7'($urandom_range(2, 4)));
                send_item(CMD_RUN, '0, '0);
                flood_done = 1;
                continue;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)      write_node_count(7'd64);
            else if (pick == 1) write_node_count(7'($urandom_range(65, 127)));
            else if (pick < 7)  write_node_count(7'($urandom_range(1, 8)));
            else if (pick == 7) write_node_count(7'($urandom_range(9, 63)));
            n = active_nodes();
            edges = $urandom_range(0, (n < 4) ? 3 : 10);
            for (int k = 0; k < edges; k++) begin
                pick = $urandom_range(0, 19);
                u = 7'($urandom_range(1, n));
                v = 7'($urandom_range(1, n));
                if (pick < 15) begin
                    // forward edge keeps the graph acyclic, but for a self loop on the last node
                    if (u > v) begin u ^= v; v ^= u; u ^= v; end
                    if (u == v && v < n) v = v + 1;
                end else if (pick == 15) begin
                    u = 7'($urandom_range(0, 127));
                end else if (pick == 16) begin
                    v = 7'($urandom_range(0, 127));
                end
                send_item(CMD_ADD, u, v);
            end
            send_item(CMD_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        end

        s_axis_tvalid = 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: topological_sort_kahn.f
+incdir+rtl
rtl/tsk_pkg.sv
rtl/tsk_ctrl.sv
rtl/tsk_dp.sv
rtl/topological_sort_kahn.sv
tb/tb.sv
